/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the operand unpack block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is applied
`define FOUC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is applied
`define FOUC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/fouc_pkg.sv */
// shared types and constants of the float operand unpack and classify block
package fouc_pkg;

  // fixed field widths
  localparam int unsigned OPERAND_W = 64;
  localparam int unsigned UEXP_W    = 12;
  localparam int unsigned NFRAC_W   = 52;
  localparam int unsigned CLASS_W   = 3;

  // configuration register widths and port shape
  localparam int unsigned CFG_EXP_W   = 4;
  localparam int unsigned CFG_FRAC_W  = 6;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned CFG_IDX_W   = 1;

  // format limits
  localparam int unsigned MAX_EXP_BITS_DEF  = 11;
  localparam int unsigned MAX_FRAC_BITS_DEF = 52;

  // configuration reset values
  localparam logic [CFG_EXP_W-1:0]  EXP_BITS_RST  = 4'd8;
  localparam logic [CFG_FRAC_W-1:0] FRAC_BITS_RST = 6'd23;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXP_BITS  = 1'b0,
    CFG_FRAC_BITS = 1'b1
  } cfg_idx_e;

  // operand classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_ZERO      = 3'd0,
    CLS_SUBNORMAL = 3'd1,
    CLS_NORMAL    = 3'd2,
    CLS_INFINITY  = 3'd3,
    CLS_NAN       = 3'd4
  } op_class_e;

endpackage

/* rtl/fouc_if.sv */
// request and result channel interfaces of the operand unpack block
interface fouc_req_if;
  logic                              valid;
  logic                              ready;
  logic [fouc_pkg::OPERAND_W-1:0]    operand;
  logic                              group_end;

  modport source (output valid, output operand, output group_end, input ready);
  modport sink   (input valid, input operand, input group_end, output ready);
endinterface

interface fouc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fouc_pkg::CLASS_W-1:0]      operand_class;
  logic                              sign;
  logic signed [fouc_pkg::UEXP_W-1:0] unbiased_exponent;
  logic [fouc_pkg::NFRAC_W-1:0]      normalized_fraction;
  logic                              nan_found;
  logic [fouc_pkg::OPERAND_W-1:0]    nan_result;

  modport source (output valid, output operand_class, output sign,
                  output unbiased_exponent, output normalized_fraction,
                  output nan_found, output nan_result, input ready);
  modport sink   (input valid, input operand_class, input sign,
                  input unbiased_exponent, input normalized_fraction,
                  input nan_found, input nan_result, output ready);
endinterface

/* rtl/float_operand_unpack_classify_top.sv */
// top level: operand classify, unpack and group nan propagation
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------------------------
//  req_i    | in  | valid/ready  | operand, group_end
//  rsp_o    | out | valid/ready  | class, sign, exponent, fraction, nan info
//  cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_wdata_i
//
// one request per cycle sustained while the result channel is not stalled; a request
// is taken into the input register, then its result is offered from the result register
// classify, leading-one search and normalize shift sit between the two registers
// reset clears valid flags and the pending nan and loads the format registers with their reset values
// a stalled result holds; the input register still fills, then ready drops
module float_operand_unpack_classify_top #(
  parameter int unsigned MAX_EXP_BITS  = fouc_pkg::MAX_EXP_BITS_DEF,
  parameter int unsigned MAX_FRAC_BITS = fouc_pkg::MAX_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fouc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fouc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  fouc_req_if.sink                         req_i,
  fouc_rsp_if.source                       rsp_o
);
  import fouc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned EXP_W   = MAX_EXP_BITS;
  localparam int unsigned FRAC_W  = MAX_FRAC_BITS;
  localparam int unsigned SH_W    = $clog2(FRAC_W + 1);
  localparam int unsigned TOT_W   = 7;
  localparam logic [CFG_EXP_W-1:0]  EXP_MAX  = CFG_EXP_W'(MAX_EXP_BITS);
  localparam logic [CFG_FRAC_W-1:0] FRAC_MAX = CFG_FRAC_W'(MAX_FRAC_BITS);
  localparam logic [CFG_EXP_W-1:0]  EXP_MIN  = CFG_EXP_W'(2);
  localparam logic [CFG_FRAC_W-1:0] FRAC_MIN = CFG_FRAC_W'(1);

  // format registers
  logic [CFG_EXP_W-1:0]  exp_bits_q;
  logic [CFG_FRAC_W-1:0] frac_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bits_q  <= EXP_BITS_RST;
      frac_bits_q <= FRAC_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXP_BITS:  exp_bits_q  <= cfg_wdata_i[CFG_EXP_W-1:0];
        CFG_FRAC_BITS: frac_bits_q <= cfg_wdata_i[CFG_FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_q, out_valid_q;
  logic [OPERAND_W-1:0] s1_op_q;
  logic s1_end_q;
  logic out_adv, s1_adv;

  assign out_adv     = !out_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && out_adv;
  assign req_i.ready = !s1_valid_q || out_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_op_q  <= req_i.operand;
      s1_end_q <= req_i.group_end;
    end
  end

  // clamp the format widths
  logic [CFG_EXP_W-1:0]  e_w;
  logic [CFG_FRAC_W-1:0] f_w;

  always_comb begin
    e_w = exp_bits_q;
    if (exp_bits_q < EXP_MIN) e_w = EXP_MIN;
    if (exp_bits_q > EXP_MAX) e_w = EXP_MAX;
    f_w = frac_bits_q;
    if (frac_bits_q < FRAC_MIN) f_w = FRAC_MIN;
    if (frac_bits_q > FRAC_MAX) f_w = FRAC_MAX;
  end

  // field extraction
  logic [TOT_W-1:0]     ef_sum;
  logic [OPERAND_W-1:0] word;
  logic [OPERAND_W-1:0] word_exp_sh;
  logic [OPERAND_W-1:0] word_sgn_sh;
  logic [EXP_W-1:0]     emask, expf, bias;
  logic [FRAC_W-1:0]    fmask, frac;
  logic                 sgn;

  always_comb begin
    ef_sum      = TOT_W'(e_w) + TOT_W'(f_w);
    word        = s1_op_q & ~({OPERAND_W{1'b1}} << (ef_sum + TOT_W'(1)));
    word_exp_sh = word >> f_w;
    word_sgn_sh = word >> ef_sum;
    emask       = ~({EXP_W{1'b1}} << e_w);
    fmask       = ~({FRAC_W{1'b1}} << f_w);
    expf        = word_exp_sh[EXP_W-1:0] & emask;
    frac        = word[FRAC_W-1:0] & fmask;
    sgn         = word_sgn_sh[0];
    bias        = ~({EXP_W{1'b1}} << (e_w - CFG_EXP_W'(1)));
  end

  // leading-one search and subnormal normalize
  logic [SH_W-1:0]   lead_pos;
  logic [SH_W-1:0]   norm_sh;
  logic [FRAC_W-1:0] sub_frac;

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      if (frac[i]) lead_pos = SH_W'(i);
    end
    norm_sh  = SH_W'(f_w) - lead_pos;
    sub_frac = (frac << norm_sh) & fmask;
  end

  // classify and build the result fields
  op_class_e         cls;
  logic [UEXP_W-1:0] uexp;
  logic [FRAC_W-1:0] ofrac;

  always_comb begin
    cls   = CLS_NORMAL;
    uexp  = UEXP_W'(expf) - UEXP_W'(bias);
    ofrac = frac;
    if (expf == '0) begin
      if (frac == '0) begin
        cls   = CLS_ZERO;
        uexp  = '0;
        ofrac = '0;
      end else begin
        cls   = CLS_SUBNORMAL;
        uexp  = UEXP_W'(1) - UEXP_W'(bias) - UEXP_W'(norm_sh);
        ofrac = sub_frac;
      end
    end else if (expf == emask) begin
      cls = (frac == '0) ? CLS_INFINITY : CLS_NAN;
    end
  end

  // first nan of the open group
  logic                 nan_pending_q, nan_pending_d;
  logic [OPERAND_W-1:0] first_nan_q, first_nan_d;
  logic                 pend_eff;
  logic [OPERAND_W-1:0] nan_word_eff, quiet_word;
  logic                 nan_found_d;
  logic [OPERAND_W-1:0] nan_result_d;

  always_comb begin
    quiet_word   = word | (OPERAND_W'(1) << (f_w - CFG_FRAC_W'(1)));
    pend_eff     = nan_pending_q || (cls == CLS_NAN);
    nan_word_eff = nan_pending_q ? first_nan_q
                 : ((cls == CLS_NAN) ? quiet_word : '0);
    nan_found_d   = 1'b0;
    nan_result_d  = '0;
    nan_pending_d = nan_pending_q;
    first_nan_d   = first_nan_q;
    if (s1_adv) begin
      if (s1_end_q) begin
        nan_found_d   = pend_eff;
        nan_result_d  = nan_word_eff;
        nan_pending_d = 1'b0;
        first_nan_d   = '0;
      end else begin
        nan_pending_d = pend_eff;
        first_nan_d   = nan_word_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nan_pending_q <= 1'b0;
      first_nan_q   <= '0;
    end else begin
      nan_pending_q <= nan_pending_d;
      first_nan_q   <= first_nan_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_o.operand_class       <= CLASS_W'(cls);
      rsp_o.sign                <= sgn;
      rsp_o.unbiased_exponent   <= uexp;
      rsp_o.normalized_fraction <= NFRAC_W'(ofrac);
      rsp_o.nan_found           <= nan_found_d;
      rsp_o.nan_result          <= nan_result_d;
    end
  end

  assign rsp_o.valid = out_valid_q;

  // checks
  `FOUC_ASSERT(a_nan_result_set, (rsp_o.valid && rsp_o.nan_found) |-> (rsp_o.nan_result != '0), "nan reported with empty word")
  `FOUC_ASSERT(a_zero_fields, (rsp_o.valid && rsp_o.operand_class == CLASS_W'(CLS_ZERO)) |-> (rsp_o.unbiased_exponent == '0 && rsp_o.normalized_fraction == '0), "zero operand with nonzero fields")
  `FOUC_ASSERT(a_full_blocks, (s1_valid_q && out_valid_q && !rsp_o.ready) |-> !req_i.ready, "request taken while pipeline is full")
  `FOUC_ASSERT(a_pending_word, nan_pending_q |-> (first_nan_q != '0), "pending nan with empty word")
  `FOUC_ASSERT_ALWAYS(a_idle_word, !nan_pending_q |-> (first_nan_q == '0), "stale nan word without pending flag")

endmodule
